// ===== hdl/u8v_pkg.sv =====
// Shared types and constants for the strict UTF-8 validator.
// Used by the front classifier, the item queue and the back sequencer.
package u8v_pkg;

    // Byte classes produced by the front classifier.
    localparam logic [2:0] KIND_ASCII = 3'd0;
    localparam logic [2:0] KIND_LEAD2 = 3'd1;
    localparam logic [2:0] KIND_LEAD3 = 3'd2;
    localparam logic [2:0] KIND_LEAD4 = 3'd3;
    localparam logic [2:0] KIND_CONT  = 3'd4;
    localparam logic [2:0] KIND_BAD   = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [20:0] MIN_SCALAR_2 = 21'h000080;
    localparam logic [20:0] MIN_SCALAR_3 = 21'h000800;
    localparam logic [20:0] MIN_SCALAR_4 = 21'h010000;
    localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW     = 21'h00D800;
    localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic       has_byte;
        logic       end_of_string;
        logic [2:0] kind;
        logic [5:0] bits;
    } u8v_item_t;

endpackage

// ===== hdl/u8v_front.sv =====
// Front classifier: decodes one input byte into a byte class and payload bits.
// Depends on u8v_pkg.
module u8v_front
    import u8v_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_string,
    output u8v_item_t  item
);

    always_comb
    begin
        item.has_byte      = has_byte;
        item.end_of_string = end_of_string;
        item.kind          = KIND_BAD;
        item.bits          = 6'd0;
        priority if (data_byte[7] == 1'b0)
        begin
            item.kind = KIND_ASCII;
        end
        else if (data_byte[7:6] == 2'b10)
        begin
            item.kind = KIND_CONT;
            item.bits = data_byte[5:0];
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            // A two-byte lead with no payload bits (0xC0) can never be valid.
            item.kind = (data_byte[4:0] == 5'd0) ? KIND_BAD : KIND_LEAD2;
            item.bits = {1'b0, data_byte[4:0]};
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            item.kind = KIND_LEAD3;
            item.bits = {2'b00, data_byte[3:0]};
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            item.kind = KIND_LEAD4;
            item.bits = {3'b000, data_byte[2:0]};
        end
        else
        begin
            item.kind = KIND_BAD;
        end
    end

endmodule

// ===== hdl/u8v_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on u8v_pkg.
module u8v_queue
    import u8v_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  u8v_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output u8v_item_t pop_item
);

    u8v_item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/u8v_back.sv =====
// Back sequencer: tracks the open multi-byte sequence, latches faults and
// holds the verdict in an output register. Depends on u8v_pkg.
module u8v_back
    import u8v_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  u8v_item_t item,
    output logic      item_take,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      is_valid
);

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] scalar_reg, scalar_next;
    logic [2:0]  length_reg, length_next;
    logic        failed_reg, failed_next;
    logic        out_valid_reg, out_valid_next;
    logic        is_valid_reg, is_valid_next;

    logic [20:0] joined;
    logic [1:0]  pending_dec;
    logic        range_bad;

    // An item that ends the string needs the output register free.
    assign item_take = item_valid
                     && !(item.end_of_string && out_valid_reg && !out_ready);
    assign out_valid = out_valid_reg;
    assign is_valid  = is_valid_reg;

    assign joined      = {scalar_reg[14:0], item.bits};
    assign pending_dec = pending_reg - 2'd1;
    assign range_bad   = ((length_reg == 3'd2) && (joined < MIN_SCALAR_2))
                      || ((length_reg == 3'd3) && (joined < MIN_SCALAR_3))
                      || ((length_reg == 3'd4) && (joined < MIN_SCALAR_4))
                      || (joined > MAX_SCALAR)
                      || ((joined >= SURR_LOW) && (joined <= SURR_HIGH));

    always_comb
    begin
        pending_next   = pending_reg;
        scalar_next    = scalar_reg;
        length_next    = length_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        is_valid_next  = is_valid_reg;

        if (item_take)
        begin
            if (item.has_byte && !failed_reg)
            begin
                if (pending_reg == 2'd0)
                begin
                    unique case (item.kind)
                        KIND_ASCII:
                        begin
                        end
                        KIND_LEAD2:
                        begin
                            scalar_next  = {15'd0, item.bits};
                            pending_next = 2'd1;
                            length_next  = 3'd2;
                        end
                        KIND_LEAD3:
                        begin
                            scalar_next  = {15'd0, item.bits};
                            pending_next = 2'd2;
                            length_next  = 3'd3;
                        end
                        KIND_LEAD4:
                        begin
                            scalar_next  = {15'd0, item.bits};
                            pending_next = 2'd3;
                            length_next  = 3'd4;
                        end
                        default:
                        begin
                            failed_next = 1'b1;
                        end
                    endcase
                end
                else if (item.kind != KIND_CONT)
                begin
                    failed_next = 1'b1;
                end
                else if (pending_dec != 2'd0)
                begin
                    scalar_next  = joined;
                    pending_next = pending_dec;
                end
                else
                begin
                    // Sequence complete: check for overlong, surrogate and range.
                    failed_next = range_bad;
                    scalar_next  = 21'd0;
                    pending_next = 2'd0;
                    length_next  = 3'd0;
                end

                if (failed_next)
                begin
                    scalar_next  = 21'd0;
                    pending_next = 2'd0;
                    length_next  = 3'd0;
                end
            end

            if (item.end_of_string)
            begin
                out_valid_next = 1'b1;
                is_valid_next  = !failed_next && (pending_next == 2'd0);
                pending_next   = 2'd0;
                scalar_next    = 21'd0;
                length_next    = 3'd0;
                failed_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            scalar_reg    <= 21'd0;
            length_reg    <= 3'd0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            scalar_reg    <= scalar_next;
            length_reg    <= length_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_valid_reg <= is_valid_next;
    end

endmodule

// ===== hdl/utf8_strict_validator.sv =====
// Strict UTF-8 validator. Bytes of a string arrive one per input item; the item
// with end_of_string high yields one verdict (is_valid) for the whole string,
// and an item without a byte may end an empty string, which is valid. The block
// sustains one item per clock: a classifier feeds a four-entry queue, and the
// back sequencer retires one item per cycle, stalling only when a verdict meets
// a full output register. The verdict is loaded into that output register when
// the back sequencer takes the item that ends the string from the queue.
module utf8_strict_validator
    import u8v_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid
);

    u8v_item_t front_item;
    u8v_item_t head_item;
    logic      queue_full;
    logic      queue_not_empty;
    logic      back_take;

    assign in_ready = !queue_full;

    u8v_front u_front (
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .item          (front_item)
    );

    u8v_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !queue_full),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (back_take),
        .not_empty (queue_not_empty),
        .pop_item  (head_item)
    );

    u8v_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .item_take  (back_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_valid   (is_valid)
    );

endmodule

// ===== hdl/u8v_checker.sv =====
// Port-level checks for the strict UTF-8 validator, bound to the top level.
// Depends only on the top level's ports.
module u8v_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       is_valid
);

    // A verdict that is not taken holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_valid))
    else $error("verdict dropped or changed while stalled");

    // No verdict is shown while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("verdict present during reset");

    // The queue is empty right after reset, so input is taken at once.
    assert property (@(posedge clk) $rose(rst_n) |-> in_ready)
    else $error("input not ready after reset");

    // The queue fills only by taking items, so ready can fall only after an offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped with nothing offered");

endmodule

bind utf8_strict_validator u8v_checker u_u8v_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_valid  (is_valid)
);

// ===== verif/tb_utf8_strict_validator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for utf8_strict_validator: directed and random byte strings,
// with a built-in predictor of the string verdict. Needs only the validator RTL and
// its package.
module tb_utf8_strict_validator;

    localparam logic [20:0] FIRST_TWO_BYTE   = 21'h000080;
    localparam logic [20:0] FIRST_THREE_BYTE = 21'h000800;
    localparam logic [20:0] FIRST_FOUR_BYTE  = 21'h010000;
    localparam logic [20:0] LAST_SCALAR      = 21'h10FFFF;
    localparam logic [20:0] SURROGATE_FIRST  = 21'h00D800;
    localparam logic [20:0] SURROGATE_LAST   = 21'h00DFFF;
    localparam int          ITEMS_PER_PHASE  = 515;
    localparam int          HOLD_CYCLES      = 300;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_string;
    } byte_item_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       out_valid;
    logic       out_ready;
    logic       is_valid;

    byte_item_t pending_items[$];
    logic       expected_verdicts[$];
    logic [7:0] str_bytes[$];
    byte_item_t next_item;

    // Predictor state for the string in progress.
    logic [1:0]  conts_due;
    logic [20:0] scalar_acc;
    logic [2:0]  seq_len;
    logic        seq_broken;

    int tx_idle_pct;
    int rx_idle_pct;
    int phase_num;
    logic hold_on;
    int mismatch_count;
    int byte_items_sent;
    int valid_seen;
    int invalid_seen;

    utf8_strict_validator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_valid      (is_valid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic byte_item_t mk_item(input logic [7:0] d, input logic h, input logic e);
        byte_item_t it;
        it.data_byte     = d;
        it.has_byte      = h;
        it.end_of_string = e;
        return it;
    endfunction

    task automatic drop_sequence();
        conts_due  = 2'd0;
        scalar_acc = 21'd0;
        seq_len    = 3'd0;
    endtask

    task automatic mark_fault();
        seq_broken = 1'b1;
        drop_sequence();
    endtask

    // Advances the decoder by one accepted item and queues the verdict on end of string.
    task automatic predict_verdict(input byte_item_t it);
        logic [7:0] b;
        b = it.data_byte;
        if (it.has_byte && !seq_broken)
        begin
            if (conts_due == 2'd0)
            begin
                if (b[7:5] == 3'b110)
                begin
                    if (b[4:0] == 5'd0)
                    begin
                        mark_fault();
                    end
                    else
                    begin
                        scalar_acc = {16'd0, b[4:0]};
                        conts_due  = 2'd1;
                        seq_len    = 3'd2;
                    end
                end
                else if (b[7:4] == 4'b1110)
                begin
                    scalar_acc = {17'd0, b[3:0]};
                    conts_due  = 2'd2;
                    seq_len    = 3'd3;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    scalar_acc = {18'd0, b[2:0]};
                    conts_due  = 2'd3;
                    seq_len    = 3'd4;
                end
                else if (b[7])
                begin
                    mark_fault();
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                mark_fault();
            end
            else
            begin
                scalar_acc = {scalar_acc[14:0], b[5:0]};
                conts_due  = conts_due - 2'd1;
                if (conts_due == 2'd0)
                begin
                    if ((seq_len == 3'd2 && scalar_acc < FIRST_TWO_BYTE)
                        || (seq_len == 3'd3 && scalar_acc < FIRST_THREE_BYTE)
                        || (seq_len == 3'd4 && scalar_acc < FIRST_FOUR_BYTE)
                        || scalar_acc > LAST_SCALAR
                        || (scalar_acc >= SURROGATE_FIRST && scalar_acc <= SURROGATE_LAST))
                    begin
                        mark_fault();
                    end
                    else
                    begin
                        drop_sequence();
                    end
                end
            end
        end
        if (it.end_of_string)
        begin
            expected_verdicts.push_back(!seq_broken && conts_due == 2'd0);
            seq_broken = 1'b0;
            drop_sequence();
        end
    endtask

    // Appends the UTF-8 form of s at the given length, overlong or out of range if asked.
    task automatic add_scalar(input logic [20:0] s, input int len);
        case (len)
            1: str_bytes.push_back({1'b0, s[6:0]});
            2:
            begin
                str_bytes.push_back({3'b110, s[10:6]});
                str_bytes.push_back({2'b10, s[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, s[15:12]});
                str_bytes.push_back({2'b10, s[11:6]});
                str_bytes.push_back({2'b10, s[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, s[20:18]});
                str_bytes.push_back({2'b10, s[17:12]});
                str_bytes.push_back({2'b10, s[11:6]});
                str_bytes.push_back({2'b10, s[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] pick_scalar(input int len);
        case (len)
            1:       return 21'($urandom_range(0, 'h7F));
            2:       return 21'($urandom_range('h80, 'h7FF));
            3:       return 21'($urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h10FFFF));
        endcase
    endfunction

    task automatic load_bytes(input logic [31:0] word, input int n);
        str_bytes.delete();
        for (int i = n - 1; i >= 0; i--)
        begin
            str_bytes.push_back(word[8*i +: 8]);
        end
    endtask

    // Turns str_bytes into items, with optional idle items in between, and returns
    // the number of items that carry a byte or end the string.
    task automatic emit_string(input bit empty_term, input int idle_pct, output int n_items);
        int last;
        last    = str_bytes.size() - 1;
        n_items = 0;
        foreach (str_bytes[i])
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                pending_items.push_back(mk_item(8'($urandom_range(255)), 1'b0, 1'b0));
            end
            pending_items.push_back(mk_item(str_bytes[i], 1'b1, (i == last) && !empty_term));
            n_items++;
        end
        if (empty_term || str_bytes.size() == 0)
        begin
            pending_items.push_back(mk_item(8'($urandom_range(255)), 1'b0, 1'b1));
            n_items++;
        end
    endtask

    task automatic fill_random(input int target);
        int queued;
        int n;
        int r;
        int len;
        queued = 0;
        while (queued < target)
        begin
            str_bytes.delete();
            repeat ($urandom_range(0, 6))
            begin
                r = $urandom_range(99);
                if (r < 35)
                begin
                    add_scalar(pick_scalar(1), 1);
                end
                else if (r < 57)
                begin
                    add_scalar(pick_scalar(2), 2);
                end
                else if (r < 73)
                begin
                    add_scalar(pick_scalar(3), 3);
                end
                else if (r < 88)
                begin
                    add_scalar(pick_scalar(4), 4);
                end
                else if (r < 91)
                begin
                    // Overlong: a scalar that fits a shorter form.
                    len = $urandom_range(2, 4);
                    add_scalar(pick_scalar(len - 1), len);
                end
                else if (r < 93)
                begin
                    add_scalar(21'($urandom_range('h110000, 'h1FFFFF)), 4);
                end
                else if (r < 95)
                begin
                    add_scalar(21'($urandom_range(SURROGATE_FIRST, SURROGATE_LAST)), 3);
                end
                else if (r < 98)
                begin
                    str_bytes.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    // Sequence missing its tail bytes.
                    len = $urandom_range(2, 4);
                    add_scalar(pick_scalar(len), len);
                    repeat ($urandom_range(1, len - 1))
                    begin
                        str_bytes.delete(str_bytes.size() - 1);
                    end
                end
            end
            emit_string($urandom_range(99) < 20, 10, n);
            queued += n;
        end
    endtask

    // Sender: holds an offered item until it is taken, then maybe idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            data_byte     <= 8'd0;
            has_byte      <= 1'b0;
            end_of_string <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_verdict(mk_item(data_byte, has_byte, end_of_string));
                if (has_byte)
                begin
                    byte_items_sent++;
                end
            end
            if (in_valid && !in_ready)
            begin
                // Keep offering the same item.
            end
            else if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_item      = pending_items.pop_front();
                in_valid      <= 1'b1;
                data_byte     <= next_item.data_byte;
                has_byte      <= next_item.has_byte;
                end_of_string <= next_item.end_of_string;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each verdict against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (is_valid)
                begin
                    valid_seen++;
                end
                else
                begin
                    invalid_seen++;
                end
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, actual is_valid=%b",
                             $time, is_valid);
                    mismatch_count++;
                end
                else if (is_valid !== expected_verdicts[0])
                begin
                    $display("%0t: is_valid mismatch, expected %b, actual %b",
                             $time, expected_verdicts[0], is_valid);
                    mismatch_count++;
                    expected_verdicts.delete(0);
                end
                else
                begin
                    expected_verdicts.delete(0);
                end
            end
            out_ready <= !hold_on && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long output hold-off in the last phase, so the block fills and stalls its input.
    initial
    begin
        hold_on = 1'b0;
        wait (phase_num == 3);
        @(negedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int n;
        rst_n           = 1'b0;
        tx_idle_pct     = 26;
        rx_idle_pct     = 60;
        phase_num       = 1;
        mismatch_count  = 0;
        byte_items_sent = 0;
        valid_seen      = 0;
        invalid_seen    = 0;
        seq_broken      = 1'b0;
        drop_sequence();

        // Directed strings: empty, ASCII and range edges, the odd leads, overlong,
        // surrogate, above the last scalar, bytes after a fault, and a cut-short tail.
        str_bytes.delete();
        emit_string(1, 0, n);
        pending_items.push_back(mk_item(8'hFF, 1'b0, 1'b0));
        load_bytes(32'h00, 1);          emit_string(0, 0, n);
        load_bytes(32'h7FC280, 3);      emit_string(0, 0, n);
        load_bytes(32'hC0, 1);          emit_string(0, 0, n);
        load_bytes(32'hC1BF, 2);        emit_string(0, 0, n);
        load_bytes(32'hE09FBF, 3);      emit_string(0, 0, n);
        load_bytes(32'hEDA080, 3);      emit_string(0, 0, n);
        load_bytes(32'hF48FBFBF, 4);    emit_string(0, 0, n);
        load_bytes(32'hF5808080, 4);    emit_string(0, 0, n);
        load_bytes(32'hF841, 2);        emit_string(1, 0, n);
        load_bytes(32'hE282, 2);        emit_string(0, 0, n);

        fill_random(ITEMS_PER_PHASE);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0);
        @(negedge clk);
        tx_idle_pct = 60;
        rx_idle_pct = 26;
        phase_num   = 2;
        fill_random(ITEMS_PER_PHASE);

        wait (pending_items.size() == 0);
        @(negedge clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_random(ITEMS_PER_PHASE);
        phase_num   = 3;

        while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Checked %0d verdicts (%0d valid, %0d invalid) over %0d byte items,",
                 valid_seen + invalid_seen, valid_seen, invalid_seen, byte_items_sent);
        $display("with idling on each side in turn and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
